/* rtl/core/sbrl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbrl_pkg
// Shared widths, codes, limits and types for the sample recorder / looper.
// ----------------------------------------------------------------------------
package sbrl_pkg;

  // Parameter defaults
  localparam int DEF_BUFFER_DEPTH = 2048;
  localparam int DEF_PHASE_FRAC   = 16;

  // Field widths
  localparam int OP_W       = 3;
  localparam int SAMPLE_W   = 24;
  localparam int SYNC_W     = 18;
  localparam int SYNC_FRAC  = 16;
  localparam int STEP_W     = 24;
  localparam int SPEED_W    = 24;
  localparam int BLEN_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int PHASE_W    = 40;
  localparam int PROD_W     = STEP_W + SPEED_W;
  localparam int SUM_W      = PROD_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 3'd1;
  localparam logic [OP_W-1:0] OP_PLAY   = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 2'd2;

  // Register reset values
  localparam logic [STEP_W-1:0]         RST_PHASE_STEP    = 24'd65536;
  localparam logic signed [SPEED_W-1:0] RST_SPEED         = 24'sd65536;
  localparam logic [BLEN_W-1:0]         RST_BUFFER_LENGTH = 12'd1280;

  // Saturation limits
  localparam logic signed [PHASE_W-1:0] PHASE_MAX = {1'b0, {(PHASE_W-1){1'b1}}};
  localparam logic signed [PHASE_W-1:0] PHASE_MIN = {1'b1, {(PHASE_W-1){1'b0}}};
  localparam logic signed [SYNC_W-1:0]  SYNC_MAX  = {1'b0, {(SYNC_W-1){1'b1}}};
  localparam logic signed [SYNC_W-1:0]  SYNC_MIN  = {1'b1, {(SYNC_W-1){1'b0}}};
  localparam logic [SYNC_W-1:0]         SYNC_NEG_LIMIT = {1'b1, {(SYNC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_RECORD,
    MODE_PLAY,
    MODE_LOOP,
    MODE_DUMP
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_START,
    ST_SYNC,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_OVF,
    DIV_STEP,
    DIV_FIN
  } div_state_t;

  typedef enum logic [1:0] {
    SO_ZERO,
    SO_SAMPLE,
    SO_MEM
  } so_sel_t;

endpackage
`default_nettype wire

/* rtl/core/sbrl_sync_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbrl_sync_div
// Iterative restoring divider: sync = phase / length with saturation,
// one quotient bit per cycle after a single overflow check.
// ----------------------------------------------------------------------------
module sbrl_sync_div #(
  parameter int PHASE_FRACTION_BITS = sbrl_pkg::DEF_PHASE_FRAC,
  parameter int LEN_W               = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sbrl_pkg::PHASE_W-1:0] phase,
  input  logic        [LEN_W-1:0]             len,
  output logic                                done,
  output logic signed [sbrl_pkg::SYNC_W-1:0]  sync
);
  import sbrl_pkg::*;

  localparam int NUM_W = PHASE_W + SYNC_FRAC;
  localparam int DEN_W = LEN_W + PHASE_FRACTION_BITS + SYNC_W;
  localparam int DW    = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int CNT_W = $clog2(SYNC_W);

  div_state_t        state, state_next;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dsh;
  logic [SYNC_W-1:0] quo;
  logic              neg;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic [PHASE_W-1:0] mag;
  logic              ge;
  logic              last_step;

  assign mag       = phase[PHASE_W-1] ? (~phase + 1'b1) : phase;
  assign ge        = rem >= dsh;
  assign last_step = cnt == CNT_W'(SYNC_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) state_next = DIV_OVF;
      end
      DIV_OVF:  state_next = DIV_STEP;
      DIV_STEP: begin
        if (last_step) state_next = DIV_FIN;
      end
      DIV_FIN:  state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == DIV_FIN);
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          rem <= DW'({mag, {SYNC_FRAC{1'b0}}});
          dsh <= DW'(len) << (PHASE_FRACTION_BITS + SYNC_W - 1);
          neg <= phase[PHASE_W-1];
          cnt <= '0;
        end
      end
      DIV_OVF: begin
        // quotient needs more than SYNC_W bits: saturate
        ovf <= {1'b0, rem} >= {dsh, 1'b0};
      end
      DIV_STEP: begin
        if (ge) rem <= rem - dsh;
        quo <= {quo[SYNC_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (!neg) begin
      sync = (ovf || quo[SYNC_W-1]) ? SYNC_MAX : $signed(quo);
    end else begin
      sync = (ovf || (quo > SYNC_NEG_LIMIT)) ? SYNC_MIN : $signed(~quo + 1'b1);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sample_buffer_recorder_looper_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sample_buffer_recorder_looper_unit
// Sample recorder / looper with a fixed-point phase accumulator over one
// synchronous sample memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries an operation and a sample.
// Transport commands (record, play, loop, dump, stop) give no result; unused
// codes are dropped. A sample tick runs at most one memory access (a write in
// record mode, a read in play, loop and dump mode), then the sync divider,
// and gives one result on the output channel (out_valid / out_stall).
// A tick passes through the states CALC (memory update), START, SYNC (the sync
// divider: an overflow check, then one quotient bit per cycle for 18 bits)
// and OUT (output load); in_stall stays high until the tick returns to IDLE,
// so the next item is taken only once the output register is loaded.
// The output register holds a finished result while the receiver stalls;
// input is still taken meanwhile, but a finished tick waits in OUT for it.
// After reset a clearing pass zeroes all BUFFER_DEPTH memory entries, one
// entry per cycle, with in_stall high. The configuration channel
// (cfg_valid / cfg_ready) is always ready, also during the clearing pass.
// ----------------------------------------------------------------------------
module sample_buffer_recorder_looper_unit #(
  parameter int BUFFER_DEPTH        = sbrl_pkg::DEF_BUFFER_DEPTH,
  parameter int PHASE_FRACTION_BITS = sbrl_pkg::DEF_PHASE_FRAC
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [sbrl_pkg::OP_W-1:0]      operation,
  input  logic signed [sbrl_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sbrl_pkg::SAMPLE_W-1:0]  sample_out,
  output logic signed [sbrl_pkg::SYNC_W-1:0]    sync_pos,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [sbrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [sbrl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbrl_pkg::*;

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W = PHASE_W - PHASE_FRACTION_BITS;
  localparam int LWI_W = AW + 1;
  localparam int CMP_W = (IDX_W > LEN_W + 1) ? IDX_W : LEN_W + 1;

  // configuration
  logic        [STEP_W-1:0]  phase_step;
  logic signed [SPEED_W-1:0] speed;
  logic        [BLEN_W-1:0]  buffer_length;

  // block state
  ctl_state_t                state, state_next;
  mode_t                     mode, mode_next, cmd_mode;
  logic signed [PHASE_W-1:0] phase, phase_next;
  logic signed [LWI_W-1:0]   lwi, lwi_next;

  // per-tick work registers
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [PROD_W-1:0]   prod_q;
  so_sel_t                    so_sel, so_sel_next;
  logic                       sync_zero, sync_zero_next;

  // memory
  logic [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [SAMPLE_W-1:0] mem_wd;
  logic                calc_we, calc_re;
  logic [AW-1:0]       calc_ra;
  logic [AW-1:0]       clr_addr;
  logic                clear_last;

  // control outputs
  logic in_accept, tick_accept, cmd_accept;
  logic clearing, div_start, out_load, out_free;
  logic div_done;
  logic signed [SYNC_W-1:0] div_sync;

  // arithmetic
  logic        [LEN_W-1:0]   eff_len, len_m1;
  logic signed [PHASE_W-1:0] phase_bias, phase_rnd;
  logic signed [IDX_W-1:0]   idx;
  logic signed [CMP_W-1:0]   idx_c, len_c, lwi_c;
  logic                      idx_ge_len, idx_neg, idx_gt_lwi;
  logic signed [PROD_W-1:0]  inc;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PHASE_W-1:0] phase_sat;

  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && !in_stall;
  assign tick_accept = in_accept && (operation == OP_TICK);
  assign cmd_accept  = in_accept && (operation inside {[OP_RECORD:OP_STOP]});
  assign out_free    = !out_valid || !out_stall;
  assign clear_last  = clr_addr == AW'(BUFFER_DEPTH - 1);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= RST_PHASE_STEP;
      speed         <= RST_SPEED;
      buffer_length <= RST_BUFFER_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP:    phase_step    <= cfg_data[STEP_W-1:0];
        REG_SPEED:         speed         <= $signed(cfg_data[SPEED_W-1:0]);
        REG_BUFFER_LENGTH: buffer_length <= cfg_data[BLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- control FSM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (tick_accept) state_next = ST_CALC;
      end
      ST_CALC:  state_next = ST_START;
      ST_START: state_next = ST_SYNC;
      ST_SYNC: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    clearing  = (state == ST_CLEAR);
    div_start = (state == ST_START);
    out_load  = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // ---------------- phase and index arithmetic ----------------
  always_comb begin
    if (buffer_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(buffer_length) > 32'(BUFFER_DEPTH)) begin
      eff_len = LEN_W'(BUFFER_DEPTH);
    end else begin
      eff_len = LEN_W'(buffer_length);
    end
  end

  assign len_m1 = eff_len - 1'b1;

  // integer part truncated toward zero: bias negatives before the shift
  assign phase_bias = phase[PHASE_W-1] ?
                      PHASE_W'((64'd1 << PHASE_FRACTION_BITS) - 64'd1) : '0;
  assign phase_rnd  = phase + phase_bias;
  assign idx        = phase_rnd[PHASE_W-1:PHASE_FRACTION_BITS];

  assign idx_c      = CMP_W'(idx);
  assign len_c      = CMP_W'($signed({1'b0, eff_len}));
  assign lwi_c      = CMP_W'(lwi);
  assign idx_ge_len = idx_c >= len_c;
  assign idx_neg    = idx[IDX_W-1];
  assign idx_gt_lwi = idx_c > lwi_c;

  always_comb begin
    case (mode)
      MODE_RECORD: inc = PROD_W'(phase_step);
      MODE_DUMP:   inc = PROD_W'(1) << PHASE_FRACTION_BITS;
      default:     inc = prod_q >>> PHASE_FRACTION_BITS;
    endcase
  end

  assign sum = SUM_W'(phase) + SUM_W'(inc);

  always_comb begin
    if (sum > SUM_W'(PHASE_MAX)) begin
      phase_sat = PHASE_MAX;
    end else if (sum < SUM_W'(PHASE_MIN)) begin
      phase_sat = PHASE_MIN;
    end else begin
      phase_sat = PHASE_W'(sum);
    end
  end

  // ---------------- tick update ----------------
  always_comb begin
    mode_next      = mode;
    phase_next     = phase_sat;
    lwi_next       = lwi;
    so_sel_next    = SO_ZERO;
    sync_zero_next = 1'b1;
    calc_we        = 1'b0;
    calc_re        = 1'b0;
    calc_ra        = AW'(idx);
    case (mode)
      MODE_RECORD: begin
        so_sel_next    = SO_SAMPLE;
        sync_zero_next = 1'b0;
        if (idx_ge_len) begin
          mode_next = MODE_IDLE;
        end else if (idx_gt_lwi) begin
          lwi_next = LWI_W'(idx);
          calc_we  = !idx_neg;
        end
      end
      MODE_PLAY: begin
        so_sel_next    = SO_MEM;
        sync_zero_next = 1'b0;
        calc_re        = 1'b1;
        // past either end: hold the edge value and stop
        if (idx_ge_len) begin
          mode_next = MODE_IDLE;
          calc_ra   = AW'(len_m1);
        end else if (idx_neg) begin
          mode_next = MODE_IDLE;
          calc_ra   = '0;
        end
      end
      MODE_LOOP: begin
        so_sel_next    = SO_MEM;
        sync_zero_next = 1'b0;
        calc_re        = 1'b1;
        if (idx_ge_len) begin
          calc_ra    = '0;
          phase_next = '0;
        end else if (idx_neg) begin
          calc_ra    = AW'(len_m1);
          phase_next = PHASE_W'(len_m1) << PHASE_FRACTION_BITS;
        end
      end
      MODE_DUMP: begin
        if (idx_ge_len || idx_neg) begin
          mode_next = MODE_IDLE;
        end else begin
          so_sel_next = SO_MEM;
          calc_re     = 1'b1;
        end
      end
      default: begin
        // idle: hold the phase
        phase_next = phase;
      end
    endcase
  end

  always_comb begin
    case (operation)
      OP_RECORD: cmd_mode = MODE_RECORD;
      OP_PLAY:   cmd_mode = MODE_PLAY;
      OP_LOOP:   cmd_mode = MODE_LOOP;
      OP_DUMP:   cmd_mode = MODE_DUMP;
      default:   cmd_mode = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      phase <= '0;
      lwi   <= '1;
    end else if (cmd_accept) begin
      mode  <= cmd_mode;
      phase <= '0;
      lwi   <= '1;
    end else if (state == ST_CALC) begin
      mode  <= mode_next;
      phase <= phase_next;
      lwi   <= lwi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      sample_q <= sample_in;
      prod_q   <= $signed({1'b0, phase_step}) * speed;
    end
    if (state == ST_CALC) begin
      so_sel    <= so_sel_next;
      sync_zero <= sync_zero_next;
    end
  end

  // ---------------- sample memory ----------------
  assign mem_we = clearing || ((state == ST_CALC) && calc_we);
  assign mem_wa = clearing ? clr_addr : AW'(idx);
  assign mem_wd = clearing ? '0 : sample_q;
  assign mem_re = (state == ST_CALC) && calc_re;
  assign mem_ra = calc_ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= mem[mem_ra];
  end

  // ---------------- sync divider ----------------
  sbrl_sync_div #(
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS),
    .LEN_W               (LEN_W)
  ) u_sync_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .phase (phase),
    .len   (eff_len),
    .done  (div_done),
    .sync  (div_sync)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      case (so_sel)
        SO_SAMPLE: sample_out <= sample_q;
        SO_MEM:    sample_out <= $signed(rd_data);
        default:   sample_out <= '0;
      endcase
      sync_pos <= sync_zero ? '0 : div_sync;
    end
  end

  // ---------------- assertions ----------------
  a_write_only_record: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (clearing || (mode == MODE_RECORD)))
    else $error("memory write outside record mode or clearing pass");

  a_div_done_in_sync: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_SYNC))
    else $error("sync divider finished while control was not waiting");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result transaction raised without a finished tick");

  a_lwi_range: assert property (@(posedge clk) disable iff (rst)
    lwi >= -1)
    else $error("last written index below minus one");

endmodule
`default_nettype wire
